/* src/ihd_pkg.sv */
// Package with the types and constants of the hexadecimal-float to binary64 converter.
package ihd_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 56;
  localparam int unsigned HexExpW = 7;
  localparam int unsigned LzcW = 6;
  localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
  localparam logic [HexExpW-1:0] MissDot = 7'h2e;
  localparam logic [HexExpW-1:0] MissUnder = 7'h5f;
  localparam logic [HexExpW-1:0] MissLetterLo = 7'h41;
  localparam logic [HexExpW-1:0] MissLetterHi = 7'h5a;

  typedef struct packed {
    logic [WordW-1:0] ieee_bits;
    logic             is_missing;
  } result_t;

  typedef struct packed {
    logic [WordW-1:0] ibm_bits;
  } item_t;
endpackage

/* src/ihd_if.sv */
// Valid/ready channel interfaces for the converter's input and result transactions.
interface ihd_in_if;
  logic           valid;
  logic           ready;
  ihd_pkg::item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ihd_out_if;
  logic             valid;
  logic             ready;
  ihd_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/ibm_hex_to_ieee_double.sv */
// Top level of the hexadecimal-float to binary64 converter.
// Each item passes the input register, then the result register; one per cycle while out_o is ready.
// The input register feeds a leading-zero count, normalizing shift and round.
// The result register is loaded whenever it is empty or being drained.
// Reset clears both valid flags; payload registers are not reset.
module ibm_hex_to_ieee_double (
  input  logic          clk_i,
  input  logic          rst_ni,
  ihd_in_if.sink        in_i,
  ihd_out_if.source     out_o
);
  logic                      in_vld_q;
  logic [ihd_pkg::WordW-1:0] in_q;
  logic                      out_vld_q;
  ihd_pkg::result_t          out_q;
  ihd_pkg::result_t          res_d;
  logic                      adv;

  assign adv = !out_vld_q || out_o.ready;
  assign in_i.ready = adv || !in_vld_q;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_q <= in_i.payload.ibm_bits;
    if (adv && in_vld_q) out_q <= res_d;
  end

  logic                        sgn;
  logic [ihd_pkg::HexExpW-1:0] hex;
  logic [ihd_pkg::FracW-1:0]   frac;
  logic [ihd_pkg::LzcW-1:0]    p;
  logic [ihd_pkg::FracW-1:0]   norm;
  logic [53:0]                 sig;
  logic                        rnd;
  logic [11:0]                 bexp;
  logic                        miss;

  assign sgn = in_q[63];
  assign hex = in_q[62:56];
  assign frac = in_q[55:0];

  always_comb begin
    p = '0;
    for (int i = 0; i < ihd_pkg::FracW; i++) begin
      if (frac[i]) p = ihd_pkg::LzcW'(i);
    end
  end

  always_comb begin
    norm = frac << (6'd55 - p);
    rnd = norm[2] && (norm[3] || norm[1] || norm[0]);
    sig = {1'b0, norm[55:3]} + {53'd0, rnd};
    bexp = 12'(p) + {3'd0, hex, 2'b00} + 12'd711;
    if (sig[53]) bexp = bexp + 12'd1;
    miss = hex == ihd_pkg::MissDot || hex == ihd_pkg::MissUnder ||
           (hex >= ihd_pkg::MissLetterLo && hex <= ihd_pkg::MissLetterHi);
    if (frac == '0) begin
      res_d.is_missing = miss;
      res_d.ieee_bits = miss ? ihd_pkg::QnanBits : {sgn, 63'd0};
    end else begin
      res_d.is_missing = 1'b0;
      res_d.ieee_bits = {sgn, bexp[10:0], sig[53] ? sig[52:1] : sig[51:0]};
    end
  end
endmodule

/* src/ihd_checker.sv */
// Port checker for the converter, bound to the top level.
module ihd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input ihd_pkg::result_t out_payload
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("result dropped");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready) else $error("stall without back pressure");
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.is_missing |-> out_payload.ieee_bits == ihd_pkg::QnanBits)
    else $error("missing without NaN");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && out_ready |=> ##1 out_valid) else $error("result late");
endmodule

bind ibm_hex_to_ieee_double ihd_checker u_ihd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_payload(out_o.payload));

/* tb/sv/tb_ibm_hex_to_ieee_double.sv */
// Self-checking testbench for the hexadecimal-float to binary64 converter.
`timescale 1ns / 100ps

module tb_ibm_hex_to_ieee_double;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  logic clk_i;
  logic rst_ni;

  ihd_in_if  in_ch ();
  ihd_out_if out_ch ();

  ibm_hex_to_ieee_double dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  ihd_pkg::item_t   pending_words[$];
  ihd_pkg::result_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit stimulus_done = 0;
  bit quiet_phase = 0;
  bit hold_sender = 0;
  bit hold_start = 0;
  bit hold_done;
  int unsigned long_hold;
  int unsigned send_gap;
  int unsigned recv_gap;

  function automatic bit is_missing_exp(logic [ihd_pkg::HexExpW-1:0] ex);
    return ex == ihd_pkg::MissDot || ex == ihd_pkg::MissUnder ||
           (ex >= ihd_pkg::MissLetterLo && ex <= ihd_pkg::MissLetterHi);
  endfunction

  function automatic ihd_pkg::result_t convert_word(logic [ihd_pkg::WordW-1:0] word);
    ihd_pkg::result_t r;
    logic [ihd_pkg::FracW-1:0] frac;
    logic [ihd_pkg::HexExpW-1:0] ex;
    int msb;
    int bexp;
    int k;
    logic [63:0] sig;
    logic [63:0] rem;
    logic [63:0] half;
    r = '0;
    frac = word[ihd_pkg::FracW-1:0];
    ex = word[62:56];
    if (frac == '0) begin
      if (is_missing_exp(ex)) begin
        r.ieee_bits = ihd_pkg::QnanBits;
        r.is_missing = 1'b1;
      end else begin
        r.ieee_bits = {word[63], 63'b0};
      end
      return r;
    end
    msb = 0;
    for (int i = 0; i < ihd_pkg::FracW; i++) begin
      if (frac[i]) msb = i;
    end
    bexp = msb + 4 * (int'(ex) - 64) - 56 + 1023;
    if (msb <= 52) begin
      sig = 64'(frac) << (52 - msb);
    end else begin
      k = msb - 52;
      rem = 64'(frac) & ((64'd1 << k) - 64'd1);
      half = 64'd1 << (k - 1);
      sig = 64'(frac) >> k;
      if (rem > half || (rem == half && sig[0])) sig = sig + 64'd1;
      if (sig[53]) begin
        sig = sig >> 1;
        bexp = bexp + 1;
      end
    end
    r.ieee_bits = {word[63], bexp[10:0], sig[51:0]};
    return r;
  endfunction

  function automatic logic [ihd_pkg::WordW-1:0] random_word();
    logic [ihd_pkg::WordW-1:0] w;
    int unsigned lz;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w[ihd_pkg::FracW-1:0] = '0;
      1: w[ihd_pkg::FracW-1:0] = w[ihd_pkg::FracW-1:0] >> $urandom_range(0, 55);
      2: w[2:0] = 3'b100;
      3: begin
        lz = $urandom_range(0, 3);
        w[ihd_pkg::FracW-1:0] = w[ihd_pkg::FracW-1:0] | (56'h80_0000_0000_0000 >> lz);
        w[ihd_pkg::FracW-1:0] = w[ihd_pkg::FracW-1:0] | ((56'd1 << (3 - lz)) - 1) << 1;
        w[ihd_pkg::FracW-1:0] = w[ihd_pkg::FracW-1:0] | (((56'd1 << 53) - 1) << (3 - lz));
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_word(logic [ihd_pkg::WordW-1:0] w);
    ihd_pkg::item_t it;
    it.ibm_bits = w;
    pending_words.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    add_word(64'h0000_0000_0000_0000);
    add_word(64'h8000_0000_0000_0000);
    add_word(64'h2e00_0000_0000_0000);
    add_word(64'hdf00_0000_0000_0000);
    add_word(64'h4100_0000_0000_0000);
    add_word(64'hda00_0000_0000_0000);
    add_word(64'h4000_0000_0000_0000);
    add_word(64'h5b00_0000_0000_0000);
    add_word(64'h7f00_0000_0000_0000);
    add_word(64'h4110_0000_0000_0000);
    add_word(64'hc276_a000_0000_0000);
    add_word(64'h7fff_ffff_ffff_ffff);
    add_word(64'hffff_ffff_ffff_ffff);
    add_word(64'h0000_0000_0000_0001);
    add_word(64'h0080_0000_0000_0001);
    add_word(64'h4080_0000_0000_0004);
    add_word(64'h4080_0000_0000_000c);
    add_word(64'h4080_0000_0000_0005);
    add_word(64'h401f_ffff_ffff_ffff);
    add_word(64'h403f_ffff_ffff_fffd);
    add_word(64'h4000_ffff_ffff_ffff);
    add_word(64'h5a00_0000_0000_0001);
    add_word(64'h2e00_0000_0000_0100);
    @(posedge rst_ni);
    wait (pending_words.size() == 0 && expected_results.size() == 0);
    hold_sender = 1;
    repeat (DrainCycles) @(posedge clk_i);
    hold_sender = 0;
    for (int i = 0; i < 1900; i++) begin
      if (i == 300) begin
        wait (pending_words.size() == 0);
        hold_start = 1;
      end
      if (i == 1700) begin
        wait (pending_words.size() == 0);
        quiet_phase = 1;
      end
      add_word(random_word());
    end
    stimulus_done = 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(convert_word(in_ch.payload.ibm_bits));
        void'(pending_words.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (!quiet_phase && !hold_sender && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 5);
          in_ch.valid <= 1'b0;
        end else if (!hold_sender && pending_words.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.payload <= pending_words[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      long_hold <= 0;
      hold_done <= 1'b0;
    end else begin
      if (hold_start && !hold_done) begin
        hold_done <= 1'b1;
        long_hold <= 200;
        out_ch.ready <= 1'b0;
      end else if (long_hold != 0) begin
        long_hold <= long_hold - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    ihd_pkg::result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: ieee_bits=%h is_missing=%b",
                   out_ch.payload.ieee_bits, out_ch.payload.is_missing);
      end else begin
        want = expected_results.pop_front();
        if (want.ieee_bits !== out_ch.payload.ieee_bits ||
            want.is_missing !== out_ch.payload.is_missing) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected ieee_bits=%h is_missing=%b, got %h %b",
                     want.ieee_bits, want.is_missing,
                     out_ch.payload.ieee_bits, out_ch.payload.is_missing);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    wait (pending_words.size() == 0 && expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
